### src/lcdnws_pkg.sv
// ----------------------------------------------------------------------------
// lcdnws_pkg
// Shared types and constants for the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnws_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [1:0] CFG_SETTLE_WAIT = 2'd1;

    localparam logic [7:0] ENABLE_HIGH_RST = 8'd3;
    localparam logic [9:0] SETTLE_WAIT_RST = 10'd50;

    // Request codes.
    localparam logic [1:0] ACT_INIT    = 2'd0;
    localparam logic [1:0] ACT_COMMAND = 2'd1;
    localparam logic [1:0] ACT_DATA    = 2'd2;
    localparam logic [1:0] ACT_CURSOR  = 2'd3;

    localparam logic [7:0] CURSOR_LINE0 = 8'h80;
    localparam logic [7:0] CURSOR_LINE1 = 8'hC0;

    // Timing constants of the power-on sequence and cursor moves, in microseconds.
    localparam logic [14:0] WAIT_POWER_ON = 15'd20000;
    localparam logic [14:0] WAIT_FIRST    = 15'd5000;
    localparam logic [14:0] WAIT_SECOND   = 15'd100;
    localparam logic [14:0] WAIT_CURSOR   = 15'd50;

    // Event steps.
    localparam int          STEP_W         = 4;
    localparam logic [STEP_W-1:0] INIT_STEP_LAST = STEP_W'(12);

    // Descriptor queue between front and back.
    localparam int DESC_DEPTH = 4;
    localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
    localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);

    typedef struct packed {
        logic [7:0] enable_high_us;
        logic [9:0] settle_wait_us;
    } t_cfg;

    // Classified request.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
        logic       add_cursor_wait;
    } t_desc;

    typedef struct packed {
        logic        register_select;
        logic [3:0]  nibble;
        logic [7:0]  pulse_high_us;
        logic [14:0] wait_after_us;
        logic        last;
    } t_event;

    // Nibble of each pulsed step of the init sequence.
    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        unique case (step)
            4'd0:    nib = 4'h0;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h3;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h2;
            4'd6:    nib = 4'h8;
            4'd7:    nib = 4'h0;
            4'd8:    nib = 4'hC;
            4'd9:    nib = 4'h0;
            4'd10:   nib = 4'h6;
            4'd11:   nib = 4'h0;
            4'd12:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

### src/lcdnws_front.sv
// ----------------------------------------------------------------------------
// lcdnws_front
// Accepts requests and classifies them into descriptors for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnws_front (
    input  wire logic              i_push,
    input  wire logic              i_q_full,
    input  wire logic [1:0]        i_action,
    input  wire logic [7:0]        i_byte_value,
    input  wire logic [5:0]        i_column,
    input  wire logic              i_row,
    output logic                   o_q_wr,
    output lcdnws_pkg::t_desc      o_desc
);
    import lcdnws_pkg::*;

    logic [7:0] cursor_byte;

    // Columns above the display width still fit in eight bits, no wrap.
    assign cursor_byte = (i_row ? CURSOR_LINE1 : CURSOR_LINE0) + {2'b00, i_column};

    always_comb begin
        o_desc = '0;
        unique case (i_action)
            ACT_INIT: begin
                o_desc.is_init = 1'b1;
            end
            ACT_COMMAND: begin
                o_desc.byte_val = i_byte_value;
            end
            ACT_DATA: begin
                o_desc.rs       = 1'b1;
                o_desc.byte_val = i_byte_value;
            end
            ACT_CURSOR: begin
                o_desc.byte_val        = cursor_byte;
                o_desc.add_cursor_wait = 1'b1;
            end
            default: o_desc = '0;
        endcase
    end

    assign o_q_wr = i_push && !i_q_full;

endmodule

`default_nettype wire

### src/lcdnws_fifo.sv
// ----------------------------------------------------------------------------
// lcdnws_fifo
// Short show-ahead descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnws_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  lcdnws_pkg::t_desc      i_wdata,
    input  wire logic              i_rd,
    output logic                   o_full,
    output logic                   o_empty,
    output lcdnws_pkg::t_desc      o_rdata
);
    import lcdnws_pkg::*;

    t_desc                 r_mem [DESC_DEPTH];
    logic [DESC_PTR_W-1:0] r_wptr, n_wptr;
    logic [DESC_PTR_W-1:0] r_rptr, n_rptr;
    logic [DESC_CNT_W-1:0] r_cnt, n_cnt;
    logic                  do_wr, do_rd;

    assign o_full  = (r_cnt == DESC_CNT_W'(DESC_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_wr) begin
            n_wptr = (r_wptr == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

### src/lcdnws_back.sv
// ----------------------------------------------------------------------------
// lcdnws_back
// Steps through the pin events of each descriptor into a registered result
// slot, one event per cycle while that slot is free or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnws_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  lcdnws_pkg::t_cfg       i_cfg,
    input  wire logic              i_q_empty,
    input  lcdnws_pkg::t_desc      i_desc,
    output logic                   o_q_rd,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output lcdnws_pkg::t_event     o_event
);
    import lcdnws_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    t_event            r_out;
    t_event            ev;
    logic [14:0]       settle;
    logic              advance;

    assign settle = {5'b00000, i_cfg.settle_wait_us};

    always_comb begin
        ev = '0;
        ev.register_select = i_desc.rs;
        ev.pulse_high_us   = i_cfg.enable_high_us;
        if (i_desc.is_init) begin
            ev.nibble = init_nibble(r_step);
            ev.last   = (r_step == INIT_STEP_LAST);
            priority case (r_step)
                STEP_W'(0): begin
                    ev.pulse_high_us = '0;
                    ev.wait_after_us = WAIT_POWER_ON;
                end
                STEP_W'(1): ev.wait_after_us = settle + WAIT_FIRST;
                STEP_W'(2): ev.wait_after_us = settle + WAIT_SECOND;
                default:    ev.wait_after_us = settle;
            endcase
        end else begin
            // High nibble first, then low nibble closes the request.
            ev.nibble        = r_step[0] ? i_desc.byte_val[3:0] : i_desc.byte_val[7:4];
            ev.last          = r_step[0];
            ev.wait_after_us = (r_step[0] && i_desc.add_cursor_wait) ?
                               settle + WAIT_CURSOR : settle;
        end
    end

    assign advance = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_rd  = advance && ev.last;

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_step      = ev.last ? '0 : r_step + 1'b1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= ev;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_event = r_out;

endmodule

`default_nettype wire

### src/lcd_nibble_write_sequencer_top.sv
// An accepted request is written into the descriptor queue; its first event is then
// registered into the result slot. Events leave at one per cycle while the slot is free
// or popped; a byte request gives two events, init 13, set by the back end's step counter.
// A four-entry descriptor queue lets requests be accepted while events drain.
// Reset is synchronous, active low; both queues empty, registers to 3 us and 50 us.
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer_top
// Expands LCD requests into 4-bit bus pin events.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_nibble_write_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [5:0]  i_column,
    input  wire logic        i_row,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_register_select,
    output logic [3:0]       o_nibble,
    output logic [7:0]       o_pulse_high_us,
    output logic [14:0]      o_wait_after_us,
    output logic             o_last
);
    import lcdnws_pkg::*;

    t_cfg   r_cfg;
    t_desc  front_desc, q_desc;
    logic   q_wr, q_rd, q_full, q_empty;
    t_event out_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high_us <= ENABLE_HIGH_RST;
            r_cfg.settle_wait_us <= SETTLE_WAIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ENABLE_HIGH) begin
                r_cfg.enable_high_us <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_SETTLE_WAIT) begin
                r_cfg.settle_wait_us <= i_cfg_data;
            end
        end
    end

    lcdnws_front u_front (
        .i_push       (push),
        .i_q_full     (q_full),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_q_wr       (q_wr),
        .o_desc       (front_desc)
    );

    lcdnws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (front_desc),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_desc)
    );

    lcdnws_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_desc    (q_desc),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_event   (out_ev)
    );

    assign full              = q_full;
    assign o_register_select = out_ev.register_select;
    assign o_nibble          = out_ev.nibble;
    assign o_pulse_high_us   = out_ev.pulse_high_us;
    assign o_wait_after_us   = out_ev.wait_after_us;
    assign o_last            = out_ev.last;

endmodule

`default_nettype wire

### src/lcdnws_checker.sv
// ----------------------------------------------------------------------------
// lcdnws_checker
// Port-level checks of the LCD write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnws_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_register_select,
    input wire logic [3:0]  o_nibble,
    input wire logic [7:0]  o_pulse_high_us,
    input wire logic [14:0] o_wait_after_us,
    input wire logic        o_last
);

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting event holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_nibble) && $stable(o_last)
                              && $stable(o_wait_after_us)))
        else $error("waiting event changed");

    // Data events only ever wait the settle time.
    a_data_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_register_select) |-> (o_wait_after_us <= 15'd1023))
        else $error("data event with long wait");

    // The long power-on wait belongs to the unpulsed first init event only.
    a_power_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_wait_after_us == 15'd20000) |->
        (o_nibble == 4'h0 && !o_register_select && !o_last && o_pulse_high_us == 8'd0))
        else $error("power-on wait on wrong event");

endmodule

bind lcd_nibble_write_sequencer_top lcdnws_checker u_lcdnws_checker (.*);

`default_nettype wire
